// ----- design/dafc_pkg.sv -----
// Shared types, constants and helper functions of the actor firing controller.
package dafc_pkg;

  localparam int SLOTS        = 8;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int COUNT_W      = SLOT_W + 1;
  localparam int ID_W         = 8;
  localparam int READER_W     = 4;
  localparam int CREDIT_W     = 7;
  localparam int SLOT_COUNT_W = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 3;

  localparam logic CMD_BUFFER = 1'b0;
  localparam logic CMD_END    = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOT_COUNT     = 3'd0,
    REG_SLOT_IDS       = 3'd1,
    REG_PRODUCED_MASK  = 3'd2,
    REG_READER_COUNTS  = 3'd3,
    REG_INPLACE_ENABLE = 3'd4,
    REG_INPLACE_SLOT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ERR_OK              = 3'd0,
    ERR_UNKNOWN_ID      = 3'd1,
    ERR_NO_CREDIT       = 3'd2,
    ERR_INPUT_AFTER_END = 3'd3,
    ERR_END_ON_OUTPUT   = 3'd4,
    ERR_DUP_END         = 3'd5,
    ERR_DUP_READY       = 3'd6
  } err_t;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] desc_id;
  } in_item_t;

  typedef struct packed {
    logic fired;
    logic release_inplace;
    logic send_end;
    err_t error;
  } out_item_t;

  // Configuration as seen by the datapath, with the values derived from it.
  typedef struct packed {
    logic [SLOTS-1:0]          active;
    logic [SLOTS-1:0]          produced;
    logic [SLOTS*ID_W-1:0]     ids;
    logic [SLOTS*READER_W-1:0] readers;
    logic                      inplace_enable;
    logic [SLOT_W-1:0]         inplace_slot;
    logic [COUNT_W-1:0]        input_total;
    logic [CREDIT_W-1:0]       credit_sum;
  } cfg_t;

  typedef struct packed {
    logic               restart;
    logic [COUNT_W-1:0] ends;
  } restart_t;

  // Slots below the configured count, limited to the table size.
  function automatic logic [SLOTS-1:0] active_mask(input logic [SLOT_COUNT_W-1:0] count);
    logic [SLOTS-1:0] mask;
    mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      mask[i] = (count > SLOT_COUNT_W'(i));
    end
    return mask;
  endfunction

  function automatic logic [COUNT_W-1:0] input_count(input logic [SLOTS-1:0] active,
                                                     input logic [SLOTS-1:0] produced);
    logic [COUNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sum = sum + COUNT_W'(active[i] & ~produced[i]);
    end
    return sum;
  endfunction

endpackage

// ----- design/dafc_cfg.sv -----
// Configuration registers and the values derived from them.
module dafc_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dafc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dafc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output dafc_pkg::cfg_t                        cfg,
  output dafc_pkg::restart_t                    rs
);

  logic [dafc_pkg::SLOT_COUNT_W-1:0]            slot_count, slot_count_next;
  logic [dafc_pkg::SLOTS*dafc_pkg::ID_W-1:0]     slot_ids, slot_ids_next;
  logic [dafc_pkg::SLOTS-1:0]                   produced_mask, produced_mask_next;
  logic [dafc_pkg::SLOTS*dafc_pkg::READER_W-1:0] reader_counts, reader_counts_next;
  logic                                         inplace_enable, inplace_enable_next;
  logic [dafc_pkg::SLOT_W-1:0]                  inplace_slot, inplace_slot_next;
  logic                                         known_reg;
  logic [dafc_pkg::SLOTS-1:0]                   active;
  logic [dafc_pkg::CREDIT_W-1:0]                credit_sum;

  always_comb begin
    slot_count_next     = slot_count;
    slot_ids_next       = slot_ids;
    produced_mask_next  = produced_mask;
    reader_counts_next  = reader_counts;
    inplace_enable_next = inplace_enable;
    inplace_slot_next   = inplace_slot;
    known_reg           = 1'b1;
    unique case (dafc_pkg::cfg_reg_t'(cfg_index))
      dafc_pkg::REG_SLOT_COUNT:
        slot_count_next = cfg_data[dafc_pkg::SLOT_COUNT_W-1:0];
      dafc_pkg::REG_SLOT_IDS:
        slot_ids_next = cfg_data[dafc_pkg::SLOTS*dafc_pkg::ID_W-1:0];
      dafc_pkg::REG_PRODUCED_MASK:
        produced_mask_next = cfg_data[dafc_pkg::SLOTS-1:0];
      dafc_pkg::REG_READER_COUNTS:
        reader_counts_next = cfg_data[dafc_pkg::SLOTS*dafc_pkg::READER_W-1:0];
      dafc_pkg::REG_INPLACE_ENABLE:
        inplace_enable_next = cfg_data[0];
      dafc_pkg::REG_INPLACE_SLOT:
        inplace_slot_next = cfg_data[dafc_pkg::SLOT_W-1:0];
      default:
        known_reg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= '0;
      slot_ids       <= '0;
      produced_mask  <= '0;
      reader_counts  <= '0;
      inplace_enable <= 1'b0;
      inplace_slot   <= '0;
    end else if (cfg_write) begin
      slot_count     <= slot_count_next;
      slot_ids       <= slot_ids_next;
      produced_mask  <= produced_mask_next;
      reader_counts  <= reader_counts_next;
      inplace_enable <= inplace_enable_next;
      inplace_slot   <= inplace_slot_next;
    end
  end

  // A write to a known register restarts the run with the new input count.
  assign rs.restart = cfg_write & known_reg;
  assign rs.ends    = dafc_pkg::input_count(dafc_pkg::active_mask(slot_count_next),
                                            produced_mask_next);

  assign active = dafc_pkg::active_mask(slot_count);

  always_comb begin
    credit_sum = '0;
    for (int i = 0; i < dafc_pkg::SLOTS; i++) begin
      if (active[i] && produced_mask[i]) begin
        credit_sum = credit_sum + dafc_pkg::CREDIT_W'(
                       reader_counts[i*dafc_pkg::READER_W +: dafc_pkg::READER_W]);
      end
    end
  end

  assign cfg.active         = active;
  assign cfg.produced       = produced_mask;
  assign cfg.ids            = slot_ids;
  assign cfg.readers        = reader_counts;
  assign cfg.inplace_enable = inplace_enable;
  assign cfg.inplace_slot   = inplace_slot;
  assign cfg.input_total    = dafc_pkg::input_count(active, produced_mask);
  assign cfg.credit_sum     = credit_sum;

endmodule

// ----- design/dafc_match.sv -----
// Descriptor id lookup: lowest active slot whose id matches.
module dafc_match (
  input  logic [dafc_pkg::ID_W-1:0]             desc_id,
  input  dafc_pkg::cfg_t                        cfg,
  output logic                                  hit,
  output logic [dafc_pkg::SLOT_W-1:0]           slot
);

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    // Scan from the top so that the lowest matching slot wins.
    for (int i = dafc_pkg::SLOTS - 1; i >= 0; i--) begin
      if (cfg.active[i] && cfg.ids[i*dafc_pkg::ID_W +: dafc_pkg::ID_W] == desc_id) begin
        hit  = 1'b1;
        slot = dafc_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

// ----- design/dafc_core.sv -----
// Run state of the actor and the firing rule applied to one message.
module dafc_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dafc_pkg::cfg_t                        cfg,
  input  dafc_pkg::restart_t                    rs,
  input  logic                                  step,
  input  logic                                  command,
  input  logic                                  hit,
  input  logic [dafc_pkg::SLOT_W-1:0]           slot,
  output dafc_pkg::out_item_t                   result
);

  logic [dafc_pkg::READER_W-1:0] reader_credit [dafc_pkg::SLOTS];
  logic [dafc_pkg::READER_W-1:0] reader_credit_next [dafc_pkg::SLOTS];
  logic [dafc_pkg::SLOTS-1:0]    input_ready, input_ready_next;
  logic [dafc_pkg::SLOTS-1:0]    input_ended, input_ended_next;
  logic [dafc_pkg::CREDIT_W-1:0] credits_outstanding, credits_outstanding_next;
  logic [dafc_pkg::COUNT_W-1:0]  ready_count, ready_count_next;
  logic [dafc_pkg::COUNT_W-1:0]  ends_remaining, ends_remaining_next;
  logic                          finished, finished_next;

  logic [dafc_pkg::READER_W-1:0] credit_sel;
  logic                          is_output;
  dafc_pkg::err_t                err;
  logic                          fired, release_inplace, send_end;

  assign credit_sel = reader_credit[slot];
  assign is_output  = cfg.produced[slot];

  always_comb begin
    reader_credit_next       = reader_credit;
    input_ready_next         = input_ready;
    input_ended_next         = input_ended;
    credits_outstanding_next = credits_outstanding;
    ready_count_next         = ready_count;
    ends_remaining_next      = ends_remaining;
    finished_next            = finished;
    err                      = dafc_pkg::ERR_OK;
    fired                    = 1'b0;
    release_inplace          = 1'b0;
    send_end                 = 1'b0;

    if (!finished) begin
      if (!hit) begin
        err = dafc_pkg::ERR_UNKNOWN_ID;
      end else if (command == dafc_pkg::CMD_BUFFER) begin
        if (is_output) begin
          if (credit_sel == '0 || credits_outstanding == '0) begin
            err = dafc_pkg::ERR_NO_CREDIT;
          end else begin
            reader_credit_next[slot] = credit_sel - 1'b1;
            credits_outstanding_next = credits_outstanding - 1'b1;
            // The last reader of the in-place output hands the buffer back.
            if (cfg.inplace_enable && slot == cfg.inplace_slot &&
                credit_sel == dafc_pkg::READER_W'(1)) begin
              release_inplace = 1'b1;
            end
          end
        end else if (input_ended[slot]) begin
          err = dafc_pkg::ERR_INPUT_AFTER_END;
        end else if (input_ready[slot]) begin
          err = dafc_pkg::ERR_DUP_READY;
        end else begin
          input_ready_next[slot] = 1'b1;
          ready_count_next       = ready_count + 1'b1;
        end
      end else begin
        if (is_output) begin
          err = dafc_pkg::ERR_END_ON_OUTPUT;
        end else if (input_ended[slot]) begin
          err = dafc_pkg::ERR_DUP_END;
        end else begin
          input_ended_next[slot] = 1'b1;
          if (ends_remaining != '0) begin
            ends_remaining_next = ends_remaining - 1'b1;
          end
        end
      end

      if (err == dafc_pkg::ERR_OK && credits_outstanding_next == '0) begin
        if (ready_count_next == cfg.input_total) begin
          fired            = 1'b1;
          input_ready_next = '0;
          for (int i = 0; i < dafc_pkg::SLOTS; i++) begin
            reader_credit_next[i] = (cfg.active[i] && cfg.produced[i]) ?
                cfg.readers[i*dafc_pkg::READER_W +: dafc_pkg::READER_W] : '0;
          end
          credits_outstanding_next = cfg.credit_sum;
          ready_count_next         = '0;
        end else if (ready_count_next == '0 && ends_remaining_next == '0) begin
          send_end      = 1'b1;
          finished_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rs.restart) begin
      for (int i = 0; i < dafc_pkg::SLOTS; i++) begin
        reader_credit[i] <= '0;
      end
      input_ready         <= '0;
      input_ended         <= '0;
      credits_outstanding <= '0;
      ready_count         <= '0;
      ends_remaining      <= rst ? '0 : rs.ends;
      finished            <= 1'b0;
    end else if (step) begin
      reader_credit       <= reader_credit_next;
      input_ready         <= input_ready_next;
      input_ended         <= input_ended_next;
      credits_outstanding <= credits_outstanding_next;
      ready_count         <= ready_count_next;
      ends_remaining      <= ends_remaining_next;
      finished            <= finished_next;
    end
  end

  assign result.fired           = fired;
  assign result.release_inplace = release_inplace;
  assign result.send_end        = send_end;
  assign result.error           = err;

endmodule

// ----- design/dataflow_actor_firing_control_unit.sv -----
// Top level of the actor firing controller: item register, firing logic, result register.
// Each accepted message item yields exactly one result item, passing from the
// input register into the result register. A new item is taken in every cycle
// unless stalled: the item sits in an input register, the slot lookup and the update of
// the credit and ready state happen in the same cycle in which it moves into the
// result register, and the result register holds it until it is taken. Writes to
// any known configuration register restart the run state (credits, ready and end
// flags, finished) as at reset, with the end count taken from the new setup.
module dataflow_actor_firing_control_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  dafc_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dafc_pkg::out_item_t                   out_item,
  input  logic                                  cfg_write,
  input  logic [dafc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dafc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  dafc_pkg::cfg_t      cfg;
  dafc_pkg::restart_t  rs;
  dafc_pkg::in_item_t  item;
  logic                item_valid;
  logic                advance;
  logic                hit;
  logic [dafc_pkg::SLOT_W-1:0] slot;
  dafc_pkg::out_item_t result;

  // The held item moves on whenever the result register is free or being emptied.
  assign advance  = item_valid & (~out_valid | out_ready);
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  dafc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .rs        (rs)
  );

  dafc_match u_match (
    .desc_id (item.desc_id),
    .cfg     (cfg),
    .hit     (hit),
    .slot    (slot)
  );

  dafc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rs      (rs),
    .step    (advance),
    .command (item.command),
    .hit     (hit),
    .slot    (slot),
    .result  (result)
  );

endmodule
